FILE: src/bca_pkg.sv
`default_nettype none
package bca_pkg;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] temp_centi;
        logic signed [31:0] press_pa;
        logic signed [31:0] altitude;
        logic signed [31:0] climb_rate;
        logic               in_range;
    } out_item_t;

    // request into a shared arithmetic unit
    typedef struct packed {
        logic        start;
        logic [63:0] op_a;
        logic [63:0] op_b;
    } unit_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } unit_rsp_t;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_CAL_A  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_B  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_C  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QNH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd4;

    localparam logic [16:0] QNH_RESET = 17'd101325;
    localparam logic [63:0] TF_BIAS = 64'd128000;
    localparam logic [63:0] RAW_FULL = 64'd1048576;
    localparam logic [63:0] SCALE_3125 = 64'd3125;
    localparam logic signed [31:0] ALT_LOW = -32'sd100000;
    localparam logic signed [31:0] ALT_HIGH = 32'sd1200000;

endpackage
`default_nettype wire

FILE: src/baro_compensation_altimeter_top.sv
`default_nettype none
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  bca_pkg::in_item_t  (raw_temp, raw_press)
// m_        out        m_valid / m_ready  bca_pkg::out_item_t (temp, press, alt, rate, flag)
// cfg_      in         cfg_wen            cfg_index, cfg_wdata
//
// One transaction runs from accept to the next accept: 13 multiplies on the shared 32x32
// multiplier, a divide in the bit-serial 64-bit divider and the steps S_CHK, S_P, S_Q,
// S_ALT and S_OUT; a zero divisor skips S_N through S_Q, the divide among them.
// s_ready is high only while the sequencer is idle; one result register holds the
// finished transaction, and the sequencer waits at its end if that register is full.
// Synchronous active-low reset clears control state and the tracking registers.
module baro_compensation_altimeter_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire bca_pkg::in_item_t                  s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output bca_pkg::out_item_t                      m_data,
    input  wire logic                               cfg_wen,
    input  wire logic [bca_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bca_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE, S_T1, S_T2, S_T3, S_XX, S_Y, S_T, S_U, S_W, S_Z, S_CHK,
        S_N, S_DIV, S_S, S_W1, S_W2, S_P, S_Q, S_ALT, S_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    state_t      state_reg;
    logic        issued_reg;
    logic [63:0] cal_a_reg, cal_b_reg, cal_c_reg;
    logic [16:0] qnh_reg;
    logic [15:0] offset_reg;
    logic [19:0] at_reg, ap_reg;
    logic [31:0] v1_reg, e_reg, tf_reg;
    logic [63:0] x_reg, xx_reg, y_reg, acc_reg, xd_reg, pp_reg, w1_reg;
    logic signed [31:0] press_reg, alt_reg;
    logic signed [31:0] last_press_reg, last_alt_reg, rate_reg;
    logic        primed_reg;
    logic        m_valid_reg;
    bca_pkg::out_item_t m_data_reg;

    bca_pkg::unit_req_t mul_req, div_req;
    bca_pkg::unit_rsp_t mul_rsp, div_rsp;

    logic [31:0] t1_32, t2_32, t3_32, ta, td, v2, tf_sum, temp_w;
    logic [63:0] r, qtmp, q64;
    logic signed [39:0] dalt, alt40;
    logic signed [39:0] rsum, rhalf;
    logic signed [31:0] rate_w;
    logic        is_mul;

    assign t1_32 = {16'd0, cal_a_reg[15:0]};
    assign t2_32 = {{16{cal_a_reg[31]}}, cal_a_reg[31:16]};
    assign t3_32 = {{16{cal_a_reg[47]}}, cal_a_reg[47:32]};
    assign ta = {15'd0, at_reg[19:3]} - {t1_32[30:0], 1'b0};
    assign td = {16'd0, at_reg[19:4]} - t1_32;
    assign r  = mul_rsp.result;
    assign v2 = $signed(r[31:0]) >>> 14;
    assign tf_sum = v1_reg + v2;
    assign temp_w = $signed((tf_reg << 2) + tf_reg + 32'd128) >>> 8;

    assign qtmp = pp_reg + (pp_reg[63] ? 64'd255 : 64'd0);
    assign q64  = $signed(qtmp) >>> 8;

    assign dalt  = $signed({23'd0, qnh_reg}) - 40'(press_reg);
    assign alt40 = (dalt <<< 5) - (dalt <<< 1);
    assign rsum  = 40'(rate_reg) + 40'(alt_reg) - 40'(last_alt_reg);
    assign rhalf = $signed(rsum + {39'd0, rsum[39]}) >>> 1;
    assign rate_w = primed_reg ? sat32(rhalf) : 32'sd0;

    always_comb begin
        is_mul = 1'b1;
        mul_req.op_a = 64'd0;
        mul_req.op_b = 64'd0;
        case (state_reg)
            S_T1: begin
                mul_req.op_a = {32'd0, ta};
                mul_req.op_b = {32'd0, t2_32};
            end
            S_T2: begin
                mul_req.op_a = {32'd0, td};
                mul_req.op_b = {32'd0, td};
            end
            S_T3: begin
                mul_req.op_a = {32'd0, e_reg};
                mul_req.op_b = {32'd0, t3_32};
            end
            S_XX: begin
                mul_req.op_a = x_reg;
                mul_req.op_b = x_reg;
            end
            S_Y: begin
                mul_req.op_a = xx_reg;
                mul_req.op_b = sx16(cal_c_reg[15:0]);
            end
            S_T: begin
                mul_req.op_a = x_reg;
                mul_req.op_b = sx16(cal_b_reg[63:48]);
            end
            S_U: begin
                mul_req.op_a = xx_reg;
                mul_req.op_b = sx16(cal_b_reg[31:16]);
            end
            S_W: begin
                mul_req.op_a = x_reg;
                mul_req.op_b = sx16(cal_b_reg[15:0]);
            end
            S_Z: begin
                mul_req.op_a = 64'h0000_8000_0000_0000 + acc_reg;
                mul_req.op_b = {48'd0, cal_a_reg[63:48]};
            end
            S_N: begin
                mul_req.op_a = ((bca_pkg::RAW_FULL - {44'd0, ap_reg}) << 31) - y_reg;
                mul_req.op_b = bca_pkg::SCALE_3125;
            end
            S_S: begin
                mul_req.op_a = $signed(pp_reg) >>> 13;
                mul_req.op_b = $signed(pp_reg) >>> 13;
            end
            S_W1: begin
                mul_req.op_a = acc_reg;
                mul_req.op_b = sx16(cal_c_reg[63:48]);
            end
            S_W2: begin
                mul_req.op_a = pp_reg;
                mul_req.op_b = sx16(cal_c_reg[47:32]);
            end
            default: is_mul = 1'b0;
        endcase
        mul_req.start = is_mul && !issued_reg;
        div_req.start = (state_reg == S_DIV) && !issued_reg;
        div_req.op_a  = acc_reg;
        div_req.op_b  = xd_reg;
    end

    bca_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    bca_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            issued_reg     <= 1'b0;
            cal_a_reg      <= 64'd0;
            cal_b_reg      <= 64'd0;
            cal_c_reg      <= 64'd0;
            qnh_reg        <= bca_pkg::QNH_RESET;
            offset_reg     <= 16'd0;
            last_press_reg <= 32'sd0;
            last_alt_reg   <= 32'sd0;
            rate_reg       <= 32'sd0;
            primed_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wen) begin
                case (cfg_index)
                    bca_pkg::CFG_CAL_A:  cal_a_reg  <= cfg_wdata;
                    bca_pkg::CFG_CAL_B:  cal_b_reg  <= cfg_wdata;
                    bca_pkg::CFG_CAL_C:  cal_c_reg  <= cfg_wdata;
                    bca_pkg::CFG_QNH:    qnh_reg    <= cfg_wdata[16:0];
                    bca_pkg::CFG_OFFSET: offset_reg <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            if (mul_req.start || div_req.start) begin
                issued_reg <= 1'b1;
            end
            if (mul_rsp.done || div_rsp.done) begin
                issued_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        at_reg    <= s_data.raw_temp;
                        ap_reg    <= s_data.raw_press;
                        state_reg <= S_T1;
                    end
                end
                S_T1: if (mul_rsp.done) begin
                    v1_reg    <= $signed(r[31:0]) >>> 11;
                    state_reg <= S_T2;
                end
                S_T2: if (mul_rsp.done) begin
                    e_reg     <= $signed(r[31:0]) >>> 12;
                    state_reg <= S_T3;
                end
                S_T3: if (mul_rsp.done) begin
                    tf_reg    <= tf_sum;
                    x_reg     <= {{32{tf_sum[31]}}, tf_sum} - bca_pkg::TF_BIAS;
                    state_reg <= S_XX;
                end
                S_XX: if (mul_rsp.done) begin
                    xx_reg    <= r;
                    state_reg <= S_Y;
                end
                S_Y: if (mul_rsp.done) begin
                    y_reg     <= r;
                    state_reg <= S_T;
                end
                S_T: if (mul_rsp.done) begin
                    y_reg     <= y_reg + (r << 17) + (sx16(cal_b_reg[47:32]) << 35);
                    state_reg <= S_U;
                end
                S_U: if (mul_rsp.done) begin
                    acc_reg   <= $signed(r) >>> 8;
                    state_reg <= S_W;
                end
                S_W: if (mul_rsp.done) begin
                    acc_reg   <= acc_reg + (r << 12);
                    state_reg <= S_Z;
                end
                S_Z: if (mul_rsp.done) begin
                    xd_reg    <= $signed(r) >>> 33;
                    state_reg <= S_CHK;
                end
                S_CHK: begin
                    // zero divisor: hold the last pressure
                    if (xd_reg == 64'd0) begin
                        press_reg <= last_press_reg;
                        state_reg <= S_ALT;
                    end else begin
                        state_reg <= S_N;
                    end
                end
                S_N: if (mul_rsp.done) begin
                    acc_reg   <= r;
                    state_reg <= S_DIV;
                end
                S_DIV: if (div_rsp.done) begin
                    pp_reg    <= div_rsp.result;
                    state_reg <= S_S;
                end
                S_S: if (mul_rsp.done) begin
                    acc_reg   <= r;
                    state_reg <= S_W1;
                end
                S_W1: if (mul_rsp.done) begin
                    w1_reg    <= $signed(r) >>> 25;
                    state_reg <= S_W2;
                end
                S_W2: if (mul_rsp.done) begin
                    acc_reg   <= pp_reg + w1_reg + 64'($signed(r) >>> 19);
                    state_reg <= S_P;
                end
                S_P: begin
                    pp_reg    <= 64'($signed(acc_reg) >>> 8) + (sx16(cal_c_reg[31:16]) << 4);
                    state_reg <= S_Q;
                end
                S_Q: begin
                    press_reg      <= {{16{offset_reg[15]}}, offset_reg} + q64[31:0];
                    last_press_reg <= {{16{offset_reg[15]}}, offset_reg} + q64[31:0];
                    state_reg      <= S_ALT;
                end
                S_ALT: begin
                    alt_reg   <= sat32(alt40);
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // wait for the result register to free up
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg           <= 1'b1;
                        m_data_reg.temp_centi <= temp_w;
                        m_data_reg.press_pa   <= press_reg;
                        m_data_reg.altitude   <= alt_reg;
                        m_data_reg.climb_rate <= rate_w;
                        m_data_reg.in_range   <= (alt_reg >= bca_pkg::ALT_LOW)
                                                 && (alt_reg <= bca_pkg::ALT_HIGH);
                        rate_reg              <= rate_w;
                        last_alt_reg          <= alt_reg;
                        primed_reg            <= 1'b1;
                        state_reg             <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_done_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_rsp.done || div_rsp.done) |-> issued_reg)
        else $error("unit done without a pending request");

    a_one_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_rsp.done && div_rsp.done))
        else $error("both units done at once");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready stayed high after an accepted transaction");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !issued_reg)
        else $error("unit request pending while idle");

endmodule
`default_nettype wire

FILE: src/bca_mul.sv
`default_nettype none
// 64x64 multiply modulo 2^64 on one 32x32 multiplier, three partial products
module bca_mul (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire bca_pkg::unit_req_t req,
    output bca_pkg::unit_rsp_t      rsp
);

    typedef enum logic [2:0] {M_IDLE, M_P0, M_P1, M_P2, M_P3} mstate_t;

    mstate_t     state_reg;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic        done_reg;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_out;

    always_comb begin
        case (state_reg)
            M_P1: begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[63:32];
            end
            M_P2: begin
                mul_x = a_reg[63:32];
                mul_y = b_reg[31:0];
            end
            default: begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[31:0];
            end
        endcase
    end

    assign mul_out = {32'd0, mul_x} * {32'd0, mul_y};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE: begin
                    if (req.start) begin
                        a_reg     <= req.op_a;
                        b_reg     <= req.op_b;
                        state_reg <= M_P0;
                    end
                end
                M_P0: begin
                    prod_reg  <= mul_out;
                    state_reg <= M_P1;
                end
                M_P1: begin
                    acc_reg   <= prod_reg;
                    prod_reg  <= mul_out;
                    state_reg <= M_P2;
                end
                M_P2: begin
                    acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                    prod_reg       <= mul_out;
                    state_reg      <= M_P3;
                end
                M_P3: begin
                    acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                    done_reg       <= 1'b1;
                    state_reg      <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule
`default_nettype wire

FILE: src/bca_div.sv
`default_nettype none
// signed 64-bit divide, truncating, one quotient bit per cycle
module bca_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire bca_pkg::unit_req_t req,
    output bca_pkg::unit_rsp_t      rsp
);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_t;

    dstate_t     state_reg;
    logic [63:0] num_reg;
    logic [63:0] den_reg;
    logic [63:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic        done_reg;
    logic [63:0] res_reg;
    logic [64:0] rem_sh;
    logic [64:0] diff;

    assign rem_sh = {rem_reg, num_reg[63]};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE: begin
                    if (req.start) begin
                        num_reg   <= req.op_a[63] ? (64'd0 - req.op_a) : req.op_a;
                        den_reg   <= req.op_b[63] ? (64'd0 - req.op_b) : req.op_b;
                        neg_reg   <= req.op_a[63] ^ req.op_b[63];
                        rem_reg   <= 64'd0;
                        cnt_reg   <= 6'd0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN: begin
                    if (!diff[64]) begin
                        rem_reg <= diff[63:0];
                        num_reg <= {num_reg[62:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[63:0];
                        num_reg <= {num_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) begin
                        state_reg <= D_FIX;
                    end
                end
                D_FIX: begin
                    res_reg   <= neg_reg ? (64'd0 - num_reg) : num_reg;
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    bca_pkg::in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    bca_pkg::out_item_t   m_data;
    logic        cfg_wen;
    logic [bca_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bca_pkg::CFG_DATA_W-1:0] cfg_wdata;

    baro_compensation_altimeter_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // predictor copy of configuration and tracking state
    logic [63:0]        cal_a, cal_b, cal_c;
    logic [16:0]        qnh;
    logic [15:0]        press_ofs;
    logic signed [31:0] held_press, prev_alt, avg_rate;
    logic               seen_first;

    bca_pkg::out_item_t expected_q[$];
    int        error_count;
    int        readings_sent;
    int        readings_checked;
    bit        idle_enable;
    bit        rx_holdoff;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] sext16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] div_trunc(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ma, mb, q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic bca_pkg::out_item_t compensate_reading(input bca_pkg::in_item_t rd);
        bca_pkg::out_item_t r;
        logic [31:0] t1, t2, t3, v1, v2, dt, e, tf, tc;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] x, y, p, w1, w2, q, tf64, s1, ps;
        logic signed [31:0] pr, alt, rate;
        logic signed [63:0] alt64, sum;
        t1 = {16'd0, cal_a[15:0]};
        t2 = {{16{cal_a[31]}}, cal_a[31:16]};
        t3 = {{16{cal_a[47]}}, cal_a[47:32]};
        p1 = {48'd0, cal_a[63:48]};
        p2 = sext16(cal_b[15:0]);  p3 = sext16(cal_b[31:16]);
        p4 = sext16(cal_b[47:32]); p5 = sext16(cal_b[63:48]);
        p6 = sext16(cal_c[15:0]);  p7 = sext16(cal_c[31:16]);
        p8 = sext16(cal_c[47:32]); p9 = sext16(cal_c[63:48]);

        v1 = $signed((({12'd0, rd.raw_temp} >> 3) - (t1 << 1)) * t2) >>> 11;
        dt = ({12'd0, rd.raw_temp} >> 4) - t1;
        e = $signed(dt * dt) >>> 12;
        v2 = $signed(e * t3) >>> 14;
        tf = v1 + v2;
        tc = $signed(tf * 32'd5 + 32'd128) >>> 8;

        tf64 = {{32{tf[31]}}, tf};
        x = tf64 - bca_pkg::TF_BIAS;
        y = x * x * p6;
        y = y + ((x * p5) << 17);
        y = y + (p4 << 35);
        s1 = $signed(x * x * p3) >>> 8;
        x = s1 + ((x * p2) << 12);
        x = $signed(((64'd1 << 47) + x) * p1) >>> 33;

        if (x == 64'd0) begin
            pr = held_press;
        end else begin
            p = bca_pkg::RAW_FULL - {44'd0, rd.raw_press};
            p = div_trunc(((p << 31) - y) * bca_pkg::SCALE_3125, x);
            ps = $signed(p) >>> 13;
            w1 = $signed(p9 * ps * ps) >>> 25;
            w2 = $signed(p8 * p) >>> 19;
            s1 = $signed(p + w1 + w2) >>> 8;
            p = s1 + (p7 << 4);
            q = div_trunc(p, 64'd256);
            q = sext16(press_ofs) + q;
            pr = q[31:0];
            held_press = pr;
        end

        alt64 = ($signed({47'd0, qnh}) - 64'(pr)) * 64'sd30;
        alt = clamp32(alt64);
        if (!seen_first) begin
            rate = 0;
            seen_first = 1'b1;
        end else begin
            sum = 64'(avg_rate) + (64'(alt) - 64'(prev_alt));
            rate = clamp32(sum / 64'sd2);
        end
        avg_rate = rate;
        prev_alt = alt;

        r.temp_centi = tc;
        r.press_pa   = pr;
        r.altitude   = alt;
        r.climb_rate = rate;
        r.in_range   = (alt >= bca_pkg::ALT_LOW && alt <= bca_pkg::ALT_HIGH);
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        bca_pkg::out_item_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            readings_checked++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                error_count++;
            end else begin
                exp_r = expected_q.pop_front();
                if (m_data.temp_centi !== exp_r.temp_centi) begin
                    $display("%0t: temp_centi expected %0d actual %0d", $time,
                             exp_r.temp_centi, m_data.temp_centi);
                    error_count++;
                end
                if (m_data.press_pa !== exp_r.press_pa) begin
                    $display("%0t: press_pa expected %0d actual %0d", $time,
                             exp_r.press_pa, m_data.press_pa);
                    error_count++;
                end
                if (m_data.altitude !== exp_r.altitude) begin
                    $display("%0t: altitude expected %0d actual %0d", $time,
                             exp_r.altitude, m_data.altitude);
                    error_count++;
                end
                if (m_data.climb_rate !== exp_r.climb_rate) begin
                    $display("%0t: climb_rate expected %0d actual %0d", $time,
                             exp_r.climb_rate, m_data.climb_rate);
                    error_count++;
                end
                if (m_data.in_range !== exp_r.in_range) begin
                    $display("%0t: in_range expected %0d actual %0d", $time,
                             exp_r.in_range, m_data.in_range);
                    error_count++;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (rx_holdoff) m_ready <= 1'b0;
        else if (idle_enable) m_ready <= ($urandom_range(99) >= 9);
        else m_ready <= 1'b1;
    end

    task automatic send_reading(input logic [19:0] temp_raw, input logic [19:0] press_raw);
        bca_pkg::in_item_t rd;
        if (idle_enable) begin
            while ($urandom_range(99) < 9) @(negedge aclk);
        end
        rd.raw_temp = temp_raw;
        rd.raw_press = press_raw;
        s_data <= rd;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_q.push_back(compensate_reading(rd));
        readings_sent++;
        @(negedge aclk);
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [bca_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            bca_pkg::CFG_CAL_A:  cal_a = val;
            bca_pkg::CFG_CAL_B:  cal_b = val;
            bca_pkg::CFG_CAL_C:  cal_c = val;
            bca_pkg::CFG_QNH:    qnh = val[16:0];
            bca_pkg::CFG_OFFSET: press_ofs = val[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wen <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic load_typical_cal();
        write_reg(bca_pkg::CFG_CAL_A, {16'd36477, 16'd50, 16'd26435, 16'd27504});
        write_reg(bca_pkg::CFG_CAL_B, {16'd14120 - 16'd14120 + 16'd140, 16'd2855, 16'd3024,
                                       -16'sd10685});
        write_reg(bca_pkg::CFG_CAL_C, {16'd6000, -16'sd7, 16'd15500, -16'sd7});
    endtask

    task automatic test_zero_calibration();
        // all-zero calibration: divisor zero, pressure held at zero
        send_reading(20'd0, 20'd0);
        send_reading(20'hfffff, 20'hfffff);
        send_reading(20'h80000, 20'h65000);
        drain_results();
    endtask

    task automatic test_directed_extremes();
        load_typical_cal();
        write_reg(bca_pkg::CFG_QNH, 64'd101325);
        write_reg(bca_pkg::CFG_OFFSET, 64'd0);
        send_reading(20'd519888, 20'd415148);
        send_reading(20'd0, 20'd0);
        send_reading(20'hfffff, 20'hfffff);
        send_reading(20'd0, 20'hfffff);
        send_reading(20'hfffff, 20'd0);
        send_reading(20'h55555, 20'haaaaa);
        send_reading(20'haaaaa, 20'h55555);
        drain_results();
        write_reg(bca_pkg::CFG_QNH, 64'h1ffff);
        write_reg(bca_pkg::CFG_OFFSET, 64'h8000);
        send_reading(20'd519888, 20'd415148);
        send_reading(20'd519888, 20'd0);
        drain_results();
        write_reg(bca_pkg::CFG_QNH, 64'd0);
        write_reg(bca_pkg::CFG_OFFSET, 64'h7fff);
        send_reading(20'd519888, 20'hfffff);
        send_reading(20'd519888, 20'd100);
        drain_results();
        // extreme calibration words
        write_reg(bca_pkg::CFG_CAL_A, 64'hffff_ffff_ffff_ffff);
        write_reg(bca_pkg::CFG_CAL_B, 64'h8000_8000_8000_8000);
        write_reg(bca_pkg::CFG_CAL_C, 64'h7fff_7fff_7fff_7fff);
        send_reading(20'hfffff, 20'd0);
        send_reading(20'd0, 20'hfffff);
        drain_results();
        write_reg(bca_pkg::CFG_CAL_A, 64'hffff_7fff_8000_0000);
        send_reading(20'h12345, 20'h54321);
        drain_results();
    endtask

    task automatic test_random_readings(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 150 == 0) begin
                drain_results();
                if ($urandom_range(3) == 0) begin
                    write_reg(bca_pkg::CFG_CAL_A, {$urandom, $urandom});
                    write_reg(bca_pkg::CFG_CAL_B, {$urandom, $urandom});
                    write_reg(bca_pkg::CFG_CAL_C, {$urandom, $urandom});
                end else begin
                    load_typical_cal();
                end
                write_reg(bca_pkg::CFG_QNH, 64'($urandom_range(110000, 80000)));
                write_reg(bca_pkg::CFG_OFFSET, 64'($urandom_range(16'hffff)));
            end
            // mostly plausible readings, some full-range noise
            if ($urandom_range(3) == 0)
                send_reading(20'($urandom), 20'($urandom));
            else
                send_reading(20'($urandom_range(560000, 480000)),
                             20'($urandom_range(450000, 250000)));
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        load_typical_cal();
        rx_holdoff = 1'b1;
        fork
            begin
                for (int i = 0; i < 6; i++)
                    send_reading(20'($urandom_range(560000, 480000)),
                                 20'($urandom_range(450000, 250000)));
            end
            begin
                repeat (1500) @(negedge aclk);
                rx_holdoff = 1'b0;
            end
        join
        drain_results();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_wen = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        idle_enable = 1'b0;
        rx_holdoff = 1'b0;
        error_count = 0;
        readings_sent = 0;
        readings_checked = 0;
        cal_a = '0; cal_b = '0; cal_c = '0;
        qnh = bca_pkg::QNH_RESET;
        press_ofs = '0;
        held_press = 0; prev_alt = 0; avg_rate = 0;
        seen_first = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_zero_calibration();
        test_directed_extremes();
        test_backpressure();
        // no idling on this stretch
        test_random_readings(300);
        idle_enable = 1'b1;
        test_random_readings(720);

        $display("Sent %0d readings, checked %0d results across zero, typical",
                 readings_sent, readings_checked);
        $display("and random calibrations with extreme QNH and offset values.");
        if (error_count == 0)
            $display("baro_compensation_altimeter_top test passed");
        else
            $display("baro_compensation_altimeter_top test failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("baro_compensation_altimeter_top test failed");
        $finish;
    end
endmodule
`default_nettype wire
